/* rtl/ccd_pkg.sv */
// Shared types and constants for the coin change dispenser.
// Holds the request and result payload structs, the coin value bank type with its reset values and status codes.
// No dependencies.
package ccd_pkg;

	localparam int unsigned KIND_SLOTS      = 6;
	localparam int unsigned VALUE_WIDTH     = 10;
	localparam int unsigned INSERT_WIDTH    = 8;
	localparam int unsigned AMOUNT_WIDTH    = 16;
	localparam int unsigned RETURN_WIDTH    = 16;
	localparam int unsigned APB_ADDR_WIDTH  = 5;
	localparam int unsigned APB_DATA_WIDTH  = 32;
	localparam int unsigned REG_INDEX_WIDTH = 3;

	typedef logic [VALUE_WIDTH-1:0] coin_value_t;
	typedef coin_value_t [KIND_SLOTS-1:0] value_bank_t;

	// Reset values, kind 0 in the lowest slot.
	localparam value_bank_t VALUE_RESET = {
		10'd10, 10'd20, 10'd50, 10'd100, 10'd200, 10'd500
	};

	localparam logic STATUS_PAID  = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef struct packed {
		logic [INSERT_WIDTH-1:0] inserted_0;
		logic [INSERT_WIDTH-1:0] inserted_1;
		logic [INSERT_WIDTH-1:0] inserted_2;
		logic [INSERT_WIDTH-1:0] inserted_3;
		logic [INSERT_WIDTH-1:0] inserted_4;
		logic [INSERT_WIDTH-1:0] inserted_5;
		logic [AMOUNT_WIDTH-1:0] change_amount;
	} req_item_t;

	typedef struct packed {
		logic [RETURN_WIDTH-1:0] returned_0;
		logic [RETURN_WIDTH-1:0] returned_1;
		logic [RETURN_WIDTH-1:0] returned_2;
		logic [RETURN_WIDTH-1:0] returned_3;
		logic [RETURN_WIDTH-1:0] returned_4;
		logic [RETURN_WIDTH-1:0] returned_5;
		logic                    change_status;
	} rsp_item_t;

	// Flags produced by the shared compare unit for one coin kind.
	typedef struct packed {
		logic fits;
		logic beats_best;
		logic has_coins;
	} cmp_flags_t;

	// Engine status seen by the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} eng_status_t;

endpackage

/* rtl/coin_change_dispenser.sv */
// Coin change dispenser, top level: configuration registers, dispensing engine, result register.
// Requests are handled one at a time: each coin paid takes a scan over all coin kinds through the
// shared compare unit and then a pay step; a zero amount skips the scan. Reset clears the coin
// pool and loads default coin values.
// Depends on ccd_pkg, ccd_regs, ccd_cmp_unit and ccd_engine.
module coin_change_dispenser
	import ccd_pkg::*;
#(
	parameter int unsigned NUM_KINDS        = 6,
	parameter int unsigned POOL_COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Request channel.
	input  logic                      req_valid,
	output logic                      req_stall,
	input  req_item_t                 req,
	// Result channel.
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rsp_item_t                 rsp,
	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	value_bank_t values;
	eng_status_t eng_stat;
	rsp_item_t   eng_result;
	logic        start;
	logic        take;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	// The coin values live in a small register bank; the engine reads them one kind
	// at a time during its scan.
	ccd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.values (values)
	);

	// A request is taken only while the engine is idle. The engine returns to idle
	// as soon as its result moves into the result register, so a new request can be
	// transferred while the previous result still waits downstream.
	assign req_stall = !eng_stat.idle;
	assign start     = req_valid && eng_stat.idle;

	ccd_engine #(
		.NUM_KINDS       (NUM_KINDS),
		.POOL_COUNT_WIDTH(POOL_COUNT_WIDTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.values(values),
		.start (start),
		.req   (req),
		.take  (take),
		.result(eng_result),
		.status(eng_stat)
	);

	// The finished result is loaded when the result register is empty or is being
	// drained in this same cycle.
	assign take = eng_stat.done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= eng_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// A request transfer always sets the engine working.
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !eng_stat.idle)
		else $error("engine stayed idle after a request transfer");

	// Handing over a result frees the engine and fills the result register.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (rsp_valid && eng_stat.idle))
		else $error("result hand-over did not complete");

	// A new result only ever comes from a finished engine.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(eng_stat.done))
		else $error("result appeared without a finished request");
`endif

endmodule

/* rtl/ccd_regs.sv */
// Coin value configuration registers behind an APB-style port.
// Depends on ccd_pkg.
module ccd_regs
	import ccd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	output value_bank_t               values
);

	logic [REG_INDEX_WIDTH-1:0] reg_index;
	logic                       index_ok;
	value_bank_t                values_q;

	assign reg_index = paddr[APB_ADDR_WIDTH-1:2];
	assign index_ok  = ({29'd0, reg_index} < KIND_SLOTS);
	assign pready    = 1'b1;
	assign values    = values_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			values_q <= VALUE_RESET;
		end else if (psel && penable && pwrite && index_ok) begin
			values_q[reg_index] <= pwdata[VALUE_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (index_ok) begin
			prdata[VALUE_WIDTH-1:0] = values_q[reg_index];
		end
	end

endmodule

/* rtl/ccd_cmp_unit.sv */
// Shared compare unit: judges one coin kind against the remaining amount and best count.
// Depends on ccd_pkg.
module ccd_cmp_unit
	import ccd_pkg::*;
#(
	parameter int unsigned POOL_COUNT_WIDTH = 16
) (
	input  coin_value_t                 value,
	input  logic [AMOUNT_WIDTH-1:0]     remaining,
	input  logic [POOL_COUNT_WIDTH-1:0] pool_count,
	input  logic [POOL_COUNT_WIDTH-1:0] best_count,
	output cmp_flags_t                  flags
);

	always_comb begin
		flags.fits       = (value != '0) &&
			(remaining >= {{(AMOUNT_WIDTH-VALUE_WIDTH){1'b0}}, value});
		flags.beats_best = pool_count > best_count;
		flags.has_coins  = pool_count != '0;
	end

endmodule

/* rtl/ccd_engine.sv */
// Dispensing sequencer: coin pool, per-request counters and the scan over coin kinds.
// Depends on ccd_pkg and ccd_cmp_unit.
module ccd_engine
	import ccd_pkg::*;
#(
	parameter int unsigned NUM_KINDS        = 6,
	parameter int unsigned POOL_COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  value_bank_t values,
	input  logic        start,
	input  req_item_t   req,
	input  logic        take,
	output rsp_item_t   result,
	output eng_status_t status
);

	localparam int unsigned KW = $clog2(NUM_KINDS);
	localparam logic [KW-1:0] LAST_KIND = KW'(NUM_KINDS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_PAY  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [POOL_COUNT_WIDTH-1:0] pool_q [NUM_KINDS];
	logic [RETURN_WIDTH-1:0]     paid_q [NUM_KINDS];
	coin_value_t                 vals   [NUM_KINDS];
	logic [INSERT_WIDTH-1:0]     ins_all  [KIND_SLOTS];
	logic [RETURN_WIDTH-1:0]     paid_all [KIND_SLOTS];

	logic [AMOUNT_WIDTH-1:0]     rem_q;
	logic [KW-1:0]               k_q;
	logic [KW-1:0]               fav_q;
	logic [POOL_COUNT_WIDTH-1:0] best_q;
	logic                        fav_ok_q;
	coin_value_t                 fav_val_q;
	logic [KW-1:0]               first_q;
	logic                        first_found_q;
	coin_value_t                 first_val_q;
	logic                        status_q;

	cmp_flags_t                  flags;
	coin_value_t                 val_k;
	logic [POOL_COUNT_WIDTH-1:0] pool_k;
	logic                        upd;
	logic                        ok_prev;
	logic                        found_prev;
	logic                        pay_en;
	logic [KW-1:0]               pick;
	coin_value_t                 pick_val;
	logic [AMOUNT_WIDTH-1:0]     rem_next;

	assign ins_all[0] = req.inserted_0;
	assign ins_all[1] = req.inserted_1;
	assign ins_all[2] = req.inserted_2;
	assign ins_all[3] = req.inserted_3;
	assign ins_all[4] = req.inserted_4;
	assign ins_all[5] = req.inserted_5;

	for (genvar i = 0; i < NUM_KINDS; i++) begin : g_vals
		assign vals[i] = values[i];
	end

	for (genvar i = 0; i < KIND_SLOTS; i++) begin : g_paid
		if (i < NUM_KINDS) begin : g_used
			assign paid_all[i] = paid_q[i];
		end else begin : g_unused
			assign paid_all[i] = '0;
		end
	end

	assign val_k  = vals[k_q];
	assign pool_k = pool_q[k_q];

	ccd_cmp_unit #(
		.POOL_COUNT_WIDTH(POOL_COUNT_WIDTH)
	) u_cmp (
		.value     (val_k),
		.remaining (rem_q),
		.pool_count(pool_k),
		.best_count(best_q),
		.flags     (flags)
	);

	assign upd        = flags.fits && flags.beats_best;
	assign ok_prev    = (k_q == '0) ? 1'b0 : fav_ok_q;
	assign found_prev = (k_q == '0) ? 1'b0 : first_found_q;

	assign pick     = fav_ok_q ? fav_q : first_q;
	assign pick_val = fav_ok_q ? fav_val_q : first_val_q;
	assign pay_en   = (state_q == ST_PAY) && (fav_ok_q || first_found_q);
	assign rem_next = rem_q - {{(AMOUNT_WIDTH-VALUE_WIDTH){1'b0}}, pick_val};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (start) begin
						state_q <= (req.change_amount == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (k_q == LAST_KIND) begin
						k_q     <= '0;
						state_q <= ST_PAY;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_PAY: begin
					if (!pay_en || rem_next == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Coin pool: deposit on a new request, one coin out per pay step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KINDS; i++) begin
				pool_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_KINDS; i++) begin
				logic [POOL_COUNT_WIDTH:0] sum;
				sum = {1'b0, pool_q[i]} +
					{{(POOL_COUNT_WIDTH+1-INSERT_WIDTH){1'b0}}, ins_all[i]};
				if (state_q == ST_IDLE && start) begin
					pool_q[i] <= sum[POOL_COUNT_WIDTH] ? '1 : sum[POOL_COUNT_WIDTH-1:0];
				end else if (pay_en && pick == KW'(i)) begin
					pool_q[i] <= pool_q[i] - 1'b1;
				end
			end
		end
	end

	// Per-request working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			rem_q    <= req.change_amount;
			fav_q    <= '0;
			best_q   <= '0;
			status_q <= STATUS_PAID;
			for (int i = 0; i < NUM_KINDS; i++) begin
				paid_q[i] <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			// The favoured kind moves to a kind that fits with a larger count than the best so far.
			if (upd) begin
				fav_q     <= k_q;
				best_q    <= pool_k;
				fav_ok_q  <= 1'b1;
				fav_val_q <= val_k;
			end else if (k_q == fav_q) begin
				fav_ok_q  <= flags.fits && flags.has_coins;
				fav_val_q <= val_k;
			end else begin
				fav_ok_q <= ok_prev;
			end
			// Fallback: first kind in index order that fits and has coins.
			if (!found_prev && flags.fits && flags.has_coins) begin
				first_q       <= k_q;
				first_val_q   <= val_k;
				first_found_q <= 1'b1;
			end else begin
				first_found_q <= found_prev;
			end
		end else if (state_q == ST_PAY) begin
			if (pay_en) begin
				rem_q <= rem_next;
				for (int i = 0; i < NUM_KINDS; i++) begin
					if (pick == KW'(i)) begin
						paid_q[i] <= paid_q[i] + 1'b1;
					end
				end
			end else begin
				status_q <= STATUS_SHORT;
			end
		end
	end

	always_comb begin
		result.returned_0    = paid_all[0];
		result.returned_1    = paid_all[1];
		result.returned_2    = paid_all[2];
		result.returned_3    = paid_all[3];
		result.returned_4    = paid_all[4];
		result.returned_5    = paid_all[5];
		result.change_status = status_q;
		status.idle          = state_q == ST_IDLE;
		status.done          = state_q == ST_DONE;
	end

endmodule
